// ===== hw/rtl/s2lab_pkg.sv =====
// s2lab_pkg: shared types, constants and table builders for the srgb to cielab unit
// no dependencies; imported by every module of the unit

package s2lab_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned CBRT_DEPTH_DEF = 256;

  localparam int unsigned LIN_W = 17;
  localparam int unsigned XYZ_W = 33;
  localparam int unsigned INV_W = 17;
  localparam int unsigned T_W   = 32;
  localparam int unsigned F_W   = 32;
  localparam int unsigned CBRT_W = 31;

  // front: gamma, matrix, white scale; lane: six stages; back end: two stages
  localparam int unsigned PIPE_DEPTH = 11;

  localparam logic [T_W-1:0] F_KNEE   = 32'd9509057;
  localparam logic [F_W-1:0] F_OFFSET = 32'd148102321;

  localparam logic [INV_W-1:0] INV_X_RST = 17'd68949;
  localparam logic [INV_W-1:0] INV_Y_RST = 17'd65536;
  localparam logic [INV_W-1:0] INV_Z_RST = 17'd60180;

  typedef enum logic [1:0] {
    CFG_INV_X = 2'd0,
    CFG_INV_Y = 2'd1,
    CFG_INV_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [INV_W-1:0] inv_x;
    logic [INV_W-1:0] inv_y;
    logic [INV_W-1:0] inv_z;
  } white_cfg_t;

  function automatic longint unsigned mul30(input longint unsigned a, input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned pow5_q30(input longint unsigned z);
    longint unsigned z2;
    longint unsigned z4;
    z2 = mul30(z, z);
    z4 = mul30(z2, z2);
    return mul30(z4, z);
  endfunction

  // gamma curve entry, Q16 linear light
  function automatic logic [LIN_W-1:0] gamma_entry(input int unsigned c);
    longint unsigned num;
    longint unsigned s;
    longint unsigned s2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned res;
    if (64'(c) * 64'd100000 <= 64'd1031475) begin
      res = (64'(c) * 64'd655360 + 64'd16473) / 64'd32946;
    end else begin
      num = (64'(c) * 64'd1000 + 64'd14025) << 30;
      s   = (num + 64'd134512) / 64'd269025;
      s2  = (s * s + (64'd1 << 29)) >> 30;
      lo  = 64'd0;
      hi  = 64'd1 << 30;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (pow5_q30(mid) <= s2) lo = mid;
        else hi = mid - 64'd1;
      end
      res = (mul30(s2, lo) + 64'd8192) >> 14;
    end
    return LIN_W'(res);
  endfunction

  // floor cube root in Q30 of 1 + i / 2^ld
  function automatic logic [CBRT_W-1:0] cbrt_entry(input int unsigned i, input int unsigned ld);
    longint unsigned m;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    m  = ((64'd1 << ld) + 64'(i)) << (30 - ld);
    lo = 64'd1 << 30;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (mul30(mul30(mid, mid), mid) <= m) lo = mid;
      else hi = mid - 64'd1;
    end
    return CBRT_W'(lo);
  endfunction

endpackage

// ===== hw/rtl/s2lab_front.sv =====
// s2lab_front: gamma rom, rgb to xyz matrix and white point scaling, three stages
// depends on s2lab_pkg

module s2lab_front import s2lab_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  white_cfg_t       cfg_i,
  output logic [T_W-1:0]   tx_o,
  output logic [T_W-1:0]   ty_o,
  output logic [T_W-1:0]   tz_o
);

  logic [LIN_W-1:0] gamma_tab [256];
  logic [LIN_W-1:0] lr_q, lg_q, lb_q;
  logic [XYZ_W-1:0] x_q, y_q, z_q;
  logic [XYZ_W-1:0] x_d, y_d, z_d;
  logic [49:0]      px, py, pz;
  logic [T_W-1:0]   tx_q, ty_q, tz_q;

  for (genvar c = 0; c < 256; c++) begin : g_gamma
    assign gamma_tab[c] = gamma_entry(c);
  end

  always_comb begin
    x_d = {16'd0, lr_q} * 33'd27027 + {16'd0, lg_q} * 33'd23436 + {16'd0, lb_q} * 33'd11829;
    y_d = {16'd0, lr_q} * 33'd13933 + {16'd0, lg_q} * 33'd46871 + {16'd0, lb_q} * 33'd4732;
    z_d = {16'd0, lr_q} * 33'd1265  + {16'd0, lg_q} * 33'd7812  + {16'd0, lb_q} * 33'd62292;
    px  = {17'd0, x_q} * {33'd0, cfg_i.inv_x} + 50'd131072;
    py  = {17'd0, y_q} * {33'd0, cfg_i.inv_y} + 50'd131072;
    pz  = {17'd0, z_q} * {33'd0, cfg_i.inv_z} + 50'd131072;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lr_q <= gamma_tab[red_i];
      lg_q <= gamma_tab[green_i];
      lb_q <= gamma_tab[blue_i];
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= z_d;
      tx_q <= px[49:18];
      ty_q <= py[49:18];
      tz_q <= pz[49:18];
    end
  end

  assign tx_o = tx_q;
  assign ty_o = ty_q;
  assign tz_o = tz_q;

endmodule

// ===== hw/rtl/s2lab_labf.sv =====
// s2lab_labf: one lane of the lab f function, six stages
// cube root by normalization, table and interpolation; linear segment below the knee
// depends on s2lab_pkg

module s2lab_labf import s2lab_pkg::*; #(
  parameter int unsigned CBRT_TABLE_DEPTH = CBRT_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [T_W-1:0] t_i,
  output logic [F_W-1:0] f_o
);

  localparam int unsigned LD = $clog2(CBRT_TABLE_DEPTH);
  localparam logic [30:0] RECIP_1000 = 31'd1099511628;

  logic [CBRT_W-1:0] cbrt_tab [CBRT_TABLE_DEPTH+1];

  for (genvar i = 0; i <= CBRT_TABLE_DEPTH; i++) begin : g_cbrt
    assign cbrt_tab[i] = cbrt_entry(i, LD);
  end

  // stage 1: knee, linear numerator, normalization
  logic [4:0]    lead;
  logic [30:0]   mant;
  logic [29:0]   frac;
  logic [1:0]    r_d, sh_d;
  logic          knee_q1;
  logic [36:0]   n_q1;
  logic [LD-1:0] idx_q1;
  logic [29:0]   w_q1;
  logic [1:0]    r_q1, sh_q1;

  always_comb begin
    lead = 5'd0;
    for (int k = 0; k < 32; k++) begin
      if (t_i[k]) lead = 5'(k);
    end
    if (lead == 5'd31) mant = t_i[31:1];
    else mant = 31'(t_i << (5'd30 - lead));
    frac = mant[29:0];
    case (lead)
      5'd23:   begin r_d = 2'd2; sh_d = 2'd3; end
      5'd24:   begin r_d = 2'd0; sh_d = 2'd2; end
      5'd25:   begin r_d = 2'd1; sh_d = 2'd2; end
      5'd26:   begin r_d = 2'd2; sh_d = 2'd2; end
      5'd27:   begin r_d = 2'd0; sh_d = 2'd1; end
      5'd28:   begin r_d = 2'd1; sh_d = 2'd1; end
      5'd29:   begin r_d = 2'd2; sh_d = 2'd1; end
      5'd30:   begin r_d = 2'd0; sh_d = 2'd0; end
      5'd31:   begin r_d = 2'd1; sh_d = 2'd0; end
      default: begin r_d = 2'd0; sh_d = 2'd0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      knee_q1 <= (t_i <= F_KNEE);
      n_q1    <= 37'(t_i[23:0]) * 37'd7787 + 37'd500;
      idx_q1  <= frac[29 -: LD];
      w_q1    <= {frac[29-LD:0], {LD{1'b0}}};
      r_q1    <= r_d;
      sh_q1   <= sh_d;
    end
  end

  // stage 2: reciprocal partial products, table read
  logic              knee_q2;
  logic [36:0]       n_q2;
  logic [49:0]       pph_q2, ppl_q2;
  logic [CBRT_W-1:0] lo_q2, hi_q2;
  logic [29:0]       w_q2;
  logic [1:0]        r_q2, sh_q2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      knee_q2 <= knee_q1;
      n_q2    <= n_q1;
      pph_q2  <= 50'(n_q1[36:18]) * 50'(RECIP_1000);
      ppl_q2  <= 50'(n_q1[17:0]) * 50'(RECIP_1000);
      lo_q2   <= cbrt_tab[{1'b0, idx_q1}];
      hi_q2   <= cbrt_tab[(LD+1)'(idx_q1) + (LD+1)'(1)];
      w_q2    <= w_q1;
      r_q2    <= r_q1;
      sh_q2   <= sh_q1;
    end
  end

  // stage 3: quotient estimate, interpolation product
  logic [67:0]       qfull;
  logic              knee_q3;
  logic [36:0]       n_q3;
  logic [27:0]       q0_q3;
  logic [60:0]       dprod_q3;
  logic [CBRT_W-1:0] lo_q3;
  logic [1:0]        r_q3, sh_q3;

  assign qfull = {pph_q2, 18'd0} + 68'(ppl_q2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      knee_q3  <= knee_q2;
      n_q3     <= n_q2;
      q0_q3    <= qfull[67:40];
      dprod_q3 <= 61'(hi_q2 - lo_q2) * 61'(w_q2);
      lo_q3    <= lo_q2;
      r_q3     <= r_q2;
      sh_q3    <= sh_q2;
    end
  end

  // stage 4: quotient correction, interpolated root
  logic [37:0]       qchk;
  logic [27:0]       q_fix;
  logic [60:0]       dround;
  logic              knee_q4;
  logic [F_W-1:0]    lin_q4;
  logic [CBRT_W-1:0] cm_q4;
  logic [1:0]        r_q4, sh_q4;

  always_comb begin
    qchk   = 38'(q0_q3) * 38'd1000;
    q_fix  = (qchk > 38'(n_q3)) ? q0_q3 - 28'd1 : q0_q3;
    dround = dprod_q3 + (61'd1 << 29);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      knee_q4 <= knee_q3;
      lin_q4  <= 32'(q_fix) + F_OFFSET;
      cm_q4   <= lo_q3 + CBRT_W'(dround[60:30]);
      r_q4    <= r_q3;
      sh_q4   <= sh_q3;
    end
  end

  // stage 5: range factor product
  logic [30:0]    pow2;
  logic           knee_q5;
  logic [F_W-1:0] lin_q5;
  logic [61:0]    prod_q5;
  logic [1:0]     sh_q5;

  always_comb begin
    case (r_q4)
      2'd1:    pow2 = 31'd1352829926;
      2'd2:    pow2 = 31'd1704458901;
      default: pow2 = 31'd1073741824;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      knee_q5 <= knee_q4;
      lin_q5  <= lin_q4;
      prod_q5 <= 62'(cm_q4) * 62'(pow2);
      sh_q5   <= sh_q4;
    end
  end

  // stage 6: rounding, exponent shift, select
  logic [61:0]    pround;
  logic [32:0]    v;
  logic [32:0]    vs;
  logic [F_W-1:0] f_q6;

  always_comb begin
    pround = prod_q5 + (62'd1 << 29);
    v      = 33'(pround[61:30]);
    case (sh_q5)
      2'd1:    vs = (v + 33'd1) >> 1;
      2'd2:    vs = (v + 33'd2) >> 2;
      2'd3:    vs = (v + 33'd4) >> 3;
      default: vs = v;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q6 <= knee_q5 ? lin_q5 : vs[F_W-1:0];
    end
  end

  assign f_o = f_q6;

endmodule

// ===== hw/rtl/s2lab_out.sv =====
// s2lab_out: l, a, b products, rounding to output precision and saturation, two stages
// depends on s2lab_pkg

module s2lab_out import s2lab_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [F_W-1:0]      fx_i,
  input  logic [F_W-1:0]      fy_i,
  input  logic [F_W-1:0]      fz_i,
  output logic [14:0]         lightness_o,
  output logic signed [15:0]  a_star_o,
  output logic signed [15:0]  b_star_o
);

  localparam int unsigned SH   = 30 - FRAC_BITS;
  localparam int unsigned LMAX = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
  localparam logic signed [43:0] HALF  = 44'sd1 <<< (SH - 1);
  localparam logic signed [43:0] LTOP  = 44'(LMAX);
  localparam logic signed [43:0] SMAX  = 44'sd32767;
  localparam logic signed [43:0] SMIN  = -44'sd32768;

  function automatic logic signed [43:0] rnd(input logic signed [43:0] v);
    logic signed [43:0] r;
    if (v >= 0) r = (v + HALF) >>> SH;
    else r = -((-v + HALF) >>> SH);
    return r;
  endfunction

  logic signed [43:0] fx, fy, fz;
  logic signed [43:0] l_q, a_q, b_q;
  logic signed [43:0] lr, ar, br;
  logic [14:0]        light_q;
  logic signed [15:0] astar_q, bstar_q;

  assign fx = $signed({12'd0, fx_i});
  assign fy = $signed({12'd0, fy_i});
  assign fz = $signed({12'd0, fz_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q <= fy * 44'sd116 - (44'sd16 <<< 30);
      a_q <= (fx - fy) * 44'sd500;
      b_q <= (fy - fz) * 44'sd200;
    end
  end

  always_comb begin
    lr = rnd(l_q);
    ar = rnd(a_q);
    br = rnd(b_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      light_q <= (lr < 0) ? 15'd0 : ((lr > LTOP) ? 15'(LMAX) : lr[14:0]);
      astar_q <= (ar < SMIN) ? 16'sh8000 : ((ar > SMAX) ? 16'sh7fff : ar[15:0]);
      bstar_q <= (br < SMIN) ? 16'sh8000 : ((br > SMAX) ? 16'sh7fff : br[15:0]);
    end
  end

  assign lightness_o = light_q;
  assign a_star_o    = astar_q;
  assign b_star_o    = bstar_q;

endmodule

// ===== hw/rtl/srgb_to_cielab_unit.sv =====
// srgb_to_cielab_unit: top level, streaming srgb pixel in, cielab word out
// depends on s2lab_pkg, s2lab_front, s2lab_labf, s2lab_out
//
// usage:
//   input word on s_axis: red, green, blue (8 bits each, gamma encoded)
//   output word on m_axis: lightness (Q8, 0..100), a star, b star (signed Q8)
//   white point reciprocals are written on the cfg port while the unit is idle
// pipeline:
//   eleven register stages, one word per cycle back to back when nothing stalls:
//   three front stages (gamma rom, matrix, white scale), six per-channel cube
//   root stages, two output stages
// reset:
//   clears all stage valids and loads the d65 white point reciprocals
// backpressure:
//   when the output word is held and m_axis_tready is low the whole pipeline
//   freezes; s_axis_tready follows, words in flight are kept in place

module srgb_to_cielab_unit import s2lab_pkg::*; #(
  parameter int unsigned FRAC_BITS        = FRAC_BITS_DEF,
  parameter int unsigned CBRT_TABLE_DEPTH = CBRT_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // red, green, blue
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // lightness, a_star, b_star, zero pad
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_addr_i,
  input  logic [INV_W-1:0] cfg_data_i
);

  localparam int unsigned LMAX = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);

  white_cfg_t            cfg_q;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  en;
  logic [T_W-1:0]        tx, ty, tz;
  logic [F_W-1:0]        fx, fy, fz;
  logic [14:0]           lightness;
  logic signed [15:0]    a_star, b_star;

  assign en = !vld_q[PIPE_DEPTH-1] || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_x <= INV_X_RST;
      cfg_q.inv_y <= INV_Y_RST;
      cfg_q.inv_z <= INV_Z_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_INV_X: cfg_q.inv_x <= cfg_data_i;
        CFG_INV_Y: cfg_q.inv_y <= cfg_data_i;
        CFG_INV_Z: cfg_q.inv_z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  s2lab_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .cfg_i   (cfg_q),
    .tx_o    (tx),
    .ty_o    (ty),
    .tz_o    (tz)
  );

  s2lab_labf #(.CBRT_TABLE_DEPTH(CBRT_TABLE_DEPTH)) u_labf_x (
    .clk_i (clk_i), .en_i (en), .t_i (tx), .f_o (fx)
  );

  s2lab_labf #(.CBRT_TABLE_DEPTH(CBRT_TABLE_DEPTH)) u_labf_y (
    .clk_i (clk_i), .en_i (en), .t_i (ty), .f_o (fy)
  );

  s2lab_labf #(.CBRT_TABLE_DEPTH(CBRT_TABLE_DEPTH)) u_labf_z (
    .clk_i (clk_i), .en_i (en), .t_i (tz), .f_o (fz)
  );

  s2lab_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk_i       (clk_i),
    .en_i        (en),
    .fx_i        (fx),
    .fy_i        (fy),
    .fz_i        (fz),
    .lightness_o (lightness),
    .a_star_o    (a_star),
    .b_star_o    (b_star)
  );

  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];
  assign m_axis_tdata  = {1'b0, b_star, a_star, lightness};

`ifndef NO_ASSERTIONS
  a_light_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> lightness <= 15'(LMAX))
    else $error("lightness above range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld_q) && $stable(m_axis_tdata))
    else $error("pipeline moved during stall");
`endif

endmodule
